>>> design/assert_macros.svh
// assertion macros used by the segment intersection point unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SIP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define SIP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/sip_pkg.sv
// package: default widths for the segment intersection point unit
package sip_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
endpackage

>>> design/segment_intersection_point_unit.sv
// Segment intersection point unit: top level, fully pipelined datapath.
// Takes one segment pair and a sweep position per cycle while not stalled and returns one word
// of results per pair, in order. Throughput is one word per clock while the output is not
// stalled. The datapath has five stages of normalisation, cross products and multiplies, then
// a restoring divider that resolves one quotient bit per stage for both coordinates, then two
// stages to add the base point, saturate and compare against the sweep. The whole pipeline
// holds while a finished word is stalled at the output; bubbles travel with their valid bits.
`include "assert_macros.svh"

module segment_intersection_point_unit
    import sip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] a_start_x,
    input  logic signed [COORD_BITS-1:0] a_start_y,
    input  logic signed [COORD_BITS-1:0] a_end_x,
    input  logic signed [COORD_BITS-1:0] a_end_y,
    input  logic signed [COORD_BITS-1:0] b_start_x,
    input  logic signed [COORD_BITS-1:0] b_start_y,
    input  logic signed [COORD_BITS-1:0] b_end_x,
    input  logic signed [COORD_BITS-1:0] b_end_y,
    input  logic signed [31:0]           sweep_x,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic                         degenerate,
    output logic                         ahead,
    output logic signed [31:0]           point_x,
    output logic signed [31:0]           point_y
);
    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DXW  = C + 1;
    localparam int PRW  = 2 * C + 2;
    localparam int SW   = 2 * C + 3;
    localparam int MAGW = 2 * C + 2;
    localparam int DMW  = C + 1;
    localparam int MW   = DMW + MAGW;
    localparam int DW   = MW + F;
    localparam int QB   = (((C - 1 + F) > 31) ? (C - 1 + F) : 31) + 2;
    localparam int DVW  = (DW > QB) ? DW : QB + 1;
    localparam int RW   = MAGW + 1;
    localparam int PW   = QB + 2;
    localparam logic signed [PW-1:0] SAT_MAX = PW'(64'sd2147483647);
    localparam logic signed [PW-1:0] SAT_MIN = PW'(-64'sd2147483648);

    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = out_valid && out_stall;

    // stage 1: normalise and take differences
    logic signed [C-1:0]   ax0_next, ay0_next, ax1_next, ay1_next;
    logic signed [C-1:0]   bx0_next, by0_next, bx1_next, by1_next;
    logic                  v1_reg;
    logic signed [C-1:0]   ax0_1_reg, ay0_1_reg;
    logic signed [DXW-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [DXW-1:0] ex_reg, ey_reg, fx_reg, fy_reg, gx_reg, gy_reg;
    logic signed [31:0]    sw1_reg;

    always_comb
    begin
        ax0_next = (a_start_x > a_end_x) ? a_end_x   : a_start_x;
        ay0_next = (a_start_x > a_end_x) ? a_end_y   : a_start_y;
        ax1_next = (a_start_x > a_end_x) ? a_start_x : a_end_x;
        ay1_next = (a_start_x > a_end_x) ? a_start_y : a_end_y;
        bx0_next = (b_start_x > b_end_x) ? b_end_x   : b_start_x;
        by0_next = (b_start_x > b_end_x) ? b_end_y   : b_start_y;
        bx1_next = (b_start_x > b_end_x) ? b_start_x : b_end_x;
        by1_next = (b_start_x > b_end_x) ? b_start_y : b_end_y;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax0_1_reg <= ax0_next;
            ay0_1_reg <= ay0_next;
            dax_reg   <= DXW'(ax1_next) - DXW'(ax0_next);
            day_reg   <= DXW'(ay1_next) - DXW'(ay0_next);
            dbx_reg   <= DXW'(bx1_next) - DXW'(bx0_next);
            dby_reg   <= DXW'(by1_next) - DXW'(by0_next);
            ex_reg    <= DXW'(ax0_next) - DXW'(bx0_next);
            ey_reg    <= DXW'(ay0_next) - DXW'(by0_next);
            fx_reg    <= DXW'(bx1_next) - DXW'(ax0_next);
            fy_reg    <= DXW'(by1_next) - DXW'(ay0_next);
            gx_reg    <= DXW'(ax1_next) - DXW'(bx0_next);
            gy_reg    <= DXW'(ay1_next) - DXW'(by0_next);
            sw1_reg   <= sweep_x;
        end
    end

    // stage 2: cross-product terms
    logic                  v2_reg;
    logic signed [PRW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [PRW-1:0] p6_reg, p7_reg, p8_reg, p9_reg, p10_reg;
    logic signed [C-1:0]   ax0_2_reg, ay0_2_reg;
    logic signed [DXW-1:0] dax_2_reg, day_2_reg;
    logic signed [31:0]    sw2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= PRW'(ey_reg) * PRW'(dax_reg);
            p2_reg    <= PRW'(ex_reg) * PRW'(day_reg);
            p3_reg    <= PRW'(dax_reg) * PRW'(fy_reg);
            p4_reg    <= PRW'(day_reg) * PRW'(fx_reg);
            p5_reg    <= PRW'(ex_reg) * PRW'(dby_reg);
            p6_reg    <= PRW'(ey_reg) * PRW'(dbx_reg);
            p7_reg    <= PRW'(dbx_reg) * PRW'(gy_reg);
            p8_reg    <= PRW'(dby_reg) * PRW'(gx_reg);
            p9_reg    <= PRW'(dby_reg) * PRW'(dax_reg);
            p10_reg   <= PRW'(dbx_reg) * PRW'(day_reg);
            ax0_2_reg <= ax0_1_reg;
            ay0_2_reg <= ay0_1_reg;
            dax_2_reg <= dax_reg;
            day_2_reg <= day_reg;
            sw2_reg   <= sw1_reg;
        end
    end

    // stage 3: orientations, straddle test, magnitudes
    logic signed [SW-1:0] o1_next, o2_next, o3_next, o4_next, den_next, num_next;
    logic                 v3_reg, hit3_reg, dz3_reg, negx3_reg, negy3_reg;
    logic [MAGW-1:0]      dv3_reg, nm3_reg;
    logic [DMW-1:0]       dmx3_reg, dmy3_reg;
    logic signed [C-1:0]  ax0_3_reg, ay0_3_reg;
    logic signed [31:0]   sw3_reg;

    always_comb
    begin
        o1_next  = SW'(p1_reg) - SW'(p2_reg);
        o2_next  = SW'(p3_reg) - SW'(p4_reg);
        o3_next  = SW'(p5_reg) - SW'(p6_reg);
        o4_next  = SW'(p7_reg) - SW'(p8_reg);
        den_next = SW'(p9_reg) - SW'(p10_reg);
        num_next = SW'(p6_reg) - SW'(p5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit3_reg  <= !(((o1_next < 0) && (o2_next > 0)) || ((o1_next > 0) && (o2_next < 0))
                          || ((o3_next < 0) && (o4_next > 0)) || ((o3_next > 0) && (o4_next < 0)));
            dz3_reg   <= (den_next == 0);
            negx3_reg <= dax_2_reg[DXW-1] ^ num_next[SW-1] ^ den_next[SW-1];
            negy3_reg <= day_2_reg[DXW-1] ^ num_next[SW-1] ^ den_next[SW-1];
            dv3_reg   <= MAGW'(den_next[SW-1] ? -den_next : den_next);
            nm3_reg   <= MAGW'(num_next[SW-1] ? -num_next : num_next);
            dmx3_reg  <= DMW'(dax_2_reg[DXW-1] ? -dax_2_reg : dax_2_reg);
            dmy3_reg  <= DMW'(day_2_reg[DXW-1] ? -day_2_reg : day_2_reg);
            ax0_3_reg <= ax0_2_reg;
            ay0_3_reg <= ay0_2_reg;
            sw3_reg   <= sw2_reg;
        end
    end

    // stage 4: numerator products
    logic                v4_reg, hit4_reg, dz4_reg, negx4_reg, negy4_reg;
    logic [MW-1:0]       mx4_reg, my4_reg;
    logic [MAGW-1:0]     dv4_reg;
    logic signed [C-1:0] ax0_4_reg, ay0_4_reg;
    logic signed [31:0]  sw4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx4_reg   <= MW'(dmx3_reg) * MW'(nm3_reg);
            my4_reg   <= MW'(dmy3_reg) * MW'(nm3_reg);
            hit4_reg  <= hit3_reg;
            dz4_reg   <= dz3_reg;
            negx4_reg <= negx3_reg;
            negy4_reg <= negy3_reg;
            dv4_reg   <= dv3_reg;
            ax0_4_reg <= ax0_3_reg;
            ay0_4_reg <= ay0_3_reg;
            sw4_reg   <= sw3_reg;
        end
    end

    // stage 5 and divider: quotient clamp check, then one quotient bit per stage
    logic [DVW-1:0] nx_next, ny_next, hx_next, hy_next;

    logic                vd_reg   [QB+1];
    logic                hitd_reg [QB+1];
    logic                dzd_reg  [QB+1];
    logic                negxd_reg[QB+1];
    logic                negyd_reg[QB+1];
    logic                ovxd_reg [QB+1];
    logic                ovyd_reg [QB+1];
    logic [MAGW-1:0]     dvd_reg  [QB+1];
    logic [MAGW-1:0]     rx_reg   [QB+1];
    logic [MAGW-1:0]     ry_reg   [QB+1];
    logic [QB-1:0]       lx_reg   [QB+1];
    logic [QB-1:0]       ly_reg   [QB+1];
    logic [QB-1:0]       qx_reg   [QB+1];
    logic [QB-1:0]       qy_reg   [QB+1];
    logic signed [C-1:0] ax0d_reg [QB+1];
    logic signed [C-1:0] ay0d_reg [QB+1];
    logic signed [31:0]  swd_reg  [QB+1];

    always_comb
    begin
        nx_next = DVW'(mx4_reg) << F;
        ny_next = DVW'(my4_reg) << F;
        hx_next = nx_next >> QB;
        hy_next = ny_next >> QB;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hitd_reg[0]  <= hit4_reg;
            dzd_reg[0]   <= dz4_reg;
            negxd_reg[0] <= negx4_reg;
            negyd_reg[0] <= negy4_reg;
            ovxd_reg[0]  <= (hx_next >= DVW'(dv4_reg));
            ovyd_reg[0]  <= (hy_next >= DVW'(dv4_reg));
            dvd_reg[0]   <= dv4_reg;
            rx_reg[0]    <= hx_next[MAGW-1:0];
            ry_reg[0]    <= hy_next[MAGW-1:0];
            lx_reg[0]    <= nx_next[QB-1:0];
            ly_reg[0]    <= ny_next[QB-1:0];
            qx_reg[0]    <= '0;
            qy_reg[0]    <= '0;
            ax0d_reg[0]  <= ax0_4_reg;
            ay0d_reg[0]  <= ay0_4_reg;
            swd_reg[0]   <= sw4_reg;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [RW-1:0] tx_next, ty_next;
        logic          gx_next, gy_next;

        always_comb
        begin
            tx_next = {rx_reg[k], lx_reg[k][QB-1]};
            ty_next = {ry_reg[k], ly_reg[k][QB-1]};
            gx_next = (tx_next >= {1'b0, dvd_reg[k]});
            gy_next = (ty_next >= {1'b0, dvd_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[k+1]    <= gx_next ? MAGW'(tx_next - {1'b0, dvd_reg[k]})
                                          : tx_next[MAGW-1:0];
                ry_reg[k+1]    <= gy_next ? MAGW'(ty_next - {1'b0, dvd_reg[k]})
                                          : ty_next[MAGW-1:0];
                qx_reg[k+1]    <= {qx_reg[k][QB-2:0], gx_next};
                qy_reg[k+1]    <= {qy_reg[k][QB-2:0], gy_next};
                lx_reg[k+1]    <= lx_reg[k] << 1;
                ly_reg[k+1]    <= ly_reg[k] << 1;
                hitd_reg[k+1]  <= hitd_reg[k];
                dzd_reg[k+1]   <= dzd_reg[k];
                negxd_reg[k+1] <= negxd_reg[k];
                negyd_reg[k+1] <= negyd_reg[k];
                ovxd_reg[k+1]  <= ovxd_reg[k];
                ovyd_reg[k+1]  <= ovyd_reg[k];
                dvd_reg[k+1]   <= dvd_reg[k];
                ax0d_reg[k+1]  <= ax0d_reg[k];
                ay0d_reg[k+1]  <= ay0d_reg[k];
                swd_reg[k+1]   <= swd_reg[k];
            end
        end
    end

    // final stage 1: clamp quotient and add the base point
    logic [QB:0]          cqx_next, cqy_next;
    logic                 vf_reg, hitf_reg, dzf_reg;
    logic signed [PW-1:0] pxf_reg, pyf_reg;
    logic signed [31:0]   swf_reg;

    always_comb
    begin
        cqx_next = ovxd_reg[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, qx_reg[QB]};
        cqy_next = ovyd_reg[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, qy_reg[QB]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxf_reg  <= (PW'(ax0d_reg[QB]) <<< F)
                        + (negxd_reg[QB] ? -PW'(cqx_next) : PW'(cqx_next));
            pyf_reg  <= (PW'(ay0d_reg[QB]) <<< F)
                        + (negyd_reg[QB] ? -PW'(cqy_next) : PW'(cqy_next));
            hitf_reg <= hitd_reg[QB];
            dzf_reg  <= dzd_reg[QB];
            swf_reg  <= swd_reg[QB];
        end
    end

    // final stage 2: saturate and compare against the sweep
    logic               hit_reg, degenerate_reg, ahead_reg;
    logic signed [31:0] point_x_reg, point_y_reg;
    logic               out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg        <= hitf_reg;
            degenerate_reg <= dzf_reg;
            ahead_reg      <= hitf_reg && !dzf_reg && (pxf_reg >= PW'(swf_reg));
            point_x_reg    <= dzf_reg ? 32'sd0
                            : (pxf_reg > SAT_MAX) ? SAT_MAX[31:0]
                            : (pxf_reg < SAT_MIN) ? SAT_MIN[31:0] : pxf_reg[31:0];
            point_y_reg    <= dzf_reg ? 32'sd0
                            : (pyf_reg > SAT_MAX) ? SAT_MAX[31:0]
                            : (pyf_reg < SAT_MIN) ? SAT_MIN[31:0] : pyf_reg[31:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            vf_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= QB; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            vd_reg[0]     <= v4_reg;
            for (int i = 0; i < QB; i++)
            begin
                vd_reg[i+1] <= vd_reg[i];
            end
            vf_reg        <= vd_reg[QB];
            out_valid_reg <= vf_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign degenerate = degenerate_reg;
    assign ahead      = ahead_reg;
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;

    `SIP_ASSERT_IMP(a_degen_zero, out_valid && degenerate,
                    point_x == 32'sd0 && point_y == 32'sd0 && !ahead)
    `SIP_ASSERT_IMP(a_ahead_hit, out_valid && ahead, hit && !degenerate)
    `SIP_ASSERT_IMP(a_no_stall_idle, !out_valid, !in_stall)
    `SIP_ASSERT_NXT(a_stall_hold, out_valid && out_stall,
                    out_valid && $stable(point_x) && $stable(hit) && $stable(vf_reg))
endmodule
